// ===== rtl/core/dprt_pkg.sv =====
// shared types and constants of the pending record table
`default_nettype none

package dprt_pkg;

   // number of flag bits stored with each record, and their places
   localparam int FLAG_W        = 3;
   localparam int FLAG_FLUSH    = 0;
   localparam int FLAG_UNICAST  = 1;
   localparam int FLAG_AUX      = 2;

   // request kinds carried in the request tuser
   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_NEXT  = 2'd1,
      REQ_DROP  = 2'd2,
      REQ_FLUSH = 2'd3
   } req_kind_type;

   // completion codes carried in the response tuser
   typedef enum logic [1:0] {
      STAT_DONE = 2'd0,
      STAT_DUP  = 2'd1,
      STAT_FULL = 2'd2,
      STAT_NONE = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_FIND,
      S_UPDATE,
      S_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/dprt_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none

module dprt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write and one registered read each cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/dedup_pending_record_table.sv =====
// top level of the deduplicating pending record table
// A table of DEPTH records (key, three flags, read mark, age among unread
// records). push adds a key as unread unless the key is already held or the
// table is full, next returns the newest unread record and marks it read, drop
// removes a key and flush clears the table; every response carries a status
// and an empty flag. One request is handled at a time. push, next and drop
// scan the record ram once to look up the key, the free slot or the newest
// unread record, and a successful push, next, or drop of an unread record
// scans it a second time to age the unread records. A flush clears the valid
// bits without a scan. Both scans are paced by the single read and single
// write port of the record ram, one record per cycle.
// Valid bits are flip-flops cleared by reset, so no clearing pass is needed.
`default_nettype none

module dedup_pending_record_table
   import dprt_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int KEY_W = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request transaction
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata fields from bit 0: record_key, in_flush_cache, in_unicast, in_auxiliary
   input  wire logic [((KEY_W+FLAG_W+7)/8)*8-1:0] req_tdata,
   // tuser fields from bit 0: req_type
   input  wire logic [1:0]                        req_tuser,
   // response transaction
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata fields from bit 0: out_valid, out_key, out_flush_cache, out_unicast,
   // out_auxiliary, is_empty
   output logic      [((KEY_W+FLAG_W+2+7)/8)*8-1:0] rsp_tdata,
   // tuser fields from bit 0: status
   output logic      [1:0]                        rsp_tuser
);

   localparam int IDX_W      = $clog2(DEPTH);
   localparam int RANK_W     = IDX_W;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int RSP_DATA_W = ((KEY_W + FLAG_W + 2 + 7) / 8) * 8;
   // record word layout: key, flags, read mark, rank
   localparam int FLG_LO     = KEY_W;
   localparam int READ_BIT   = KEY_W + FLAG_W;
   localparam int RANK_LO    = KEY_W + FLAG_W + 1;
   localparam int ENTRY_W    = KEY_W + FLAG_W + 1 + RANK_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   // sequencer
   state_type              state_ff, state_in;

   // request held while it is worked on
   req_kind_type           op_ff, op_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [FLAG_W-1:0]      flags_ff, flags_in;

   // table bookkeeping
   logic [DEPTH-1:0]       valid_ff, valid_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   // scan pointer and the record arriving from the ram
   logic                   issue_ff, issue_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   dvld_ff, dvld_in;
   logic [IDX_W-1:0]       didx_ff, didx_in;

   // lookup results
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic                   hit_read_ff, hit_read_in;
   logic [RANK_W-1:0]      hit_rank_ff, hit_rank_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic [KEY_W-1:0]       ret_key_ff, ret_key_in;
   logic [FLAG_W-1:0]      ret_flags_ff, ret_flags_in;
   status_type             status_ff, status_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [1:0]             rsp_user_ff, rsp_user_in;

   // ram ports
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [ENTRY_W-1:0]     wr_data;
   logic [ENTRY_W-1:0]     rd_data;

   // control between datapath and sequencer
   logic                   req_accept;
   logic                   scan_last;
   logic                   go_update;
   logic                   rsp_load;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign scan_last  = dvld_ff && (didx_ff == LAST_IDX);
   assign rsp_load   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   dprt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_records (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_kind_type'(req_tuser) == REQ_FLUSH) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_FIND;
               end
            end
         end
         S_FIND: begin
            if (scan_last) begin
               state_in = go_update ? S_UPDATE : S_FINISH;
            end
         end
         S_UPDATE: begin
            if (scan_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath, ram access and response
   always_comb begin
      logic              ent_v;
      logic              ent_rd;
      logic [RANK_W-1:0] ent_rank;
      logic              fnd;
      logic              frf;
      logic [IDX_W-1:0]  hix;
      logic [RANK_W-1:0] hrk;

      ent_v    = valid_ff[didx_ff];
      ent_rd   = rd_data[READ_BIT];
      ent_rank = rd_data[RANK_LO +: RANK_W];
      fnd      = found_ff;
      frf      = free_found_ff;
      hix      = hit_idx_ff;
      hrk      = hit_rank_ff;

      op_in         = op_ff;
      key_in        = key_ff;
      flags_in      = flags_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_read_in   = hit_read_ff;
      hit_rank_in   = hit_rank_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      ret_key_in    = ret_key_ff;
      ret_flags_in  = ret_flags_ff;
      status_in     = status_ff;
      go_update     = 1'b0;

      wr_en   = 1'b0;
      wr_addr = didx_ff;
      wr_data = rd_data;

      // scan pointer runs while issuing, the ram answers in the following cycle
      dvld_in  = issue_ff;
      didx_in  = idx_ff;
      issue_in = issue_ff;
      idx_in   = idx_ff;
      if (issue_ff) begin
         idx_in   = IDX_W'(idx_ff + 1'b1);
         issue_in = (idx_ff != LAST_IDX);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in         = req_kind_type'(req_tuser);
               key_in        = req_tdata[KEY_W-1:0];
               flags_in      = req_tdata[KEY_W +: FLAG_W];
               found_in      = 1'b0;
               free_found_in = 1'b0;
               status_in     = STAT_DONE;
               if (req_kind_type'(req_tuser) == REQ_FLUSH) begin
                  valid_in = '0;
                  count_in = '0;
               end else begin
                  issue_in = 1'b1;
                  idx_in   = '0;
               end
            end
         end
         S_FIND: begin
            if (dvld_ff) begin
               case (op_ff)
                  REQ_PUSH, REQ_DROP: begin
                     // key lookup
                     if (ent_v && (rd_data[KEY_W-1:0] == key_ff) && !fnd) begin
                        fnd         = 1'b1;
                        hix         = didx_ff;
                        hrk         = ent_rank;
                        hit_read_in = ent_rd;
                     end
                     // lowest free slot
                     if (!ent_v && !frf) begin
                        frf         = 1'b1;
                        free_idx_in = didx_ff;
                     end
                  end
                  REQ_NEXT: begin
                     // newest unread record has the smallest rank
                     if (ent_v && !ent_rd && (!fnd || (ent_rank < hrk))) begin
                        fnd          = 1'b1;
                        hix          = didx_ff;
                        hrk          = ent_rank;
                        ret_key_in   = rd_data[KEY_W-1:0];
                        ret_flags_in = rd_data[FLG_LO +: FLAG_W];
                     end
                  end
                  default: begin
                  end
               endcase
               found_in      = fnd;
               free_found_in = frf;
               hit_idx_in    = hix;
               hit_rank_in   = hrk;

               // decide at the end of the lookup pass
               if (scan_last) begin
                  case (op_ff)
                     REQ_PUSH: begin
                        if (fnd) begin
                           status_in = STAT_DUP;
                        end else if (!frf) begin
                           status_in = STAT_FULL;
                        end else begin
                           go_update = 1'b1;
                        end
                     end
                     REQ_NEXT: begin
                        if (fnd) begin
                           go_update = 1'b1;
                        end else begin
                           status_in = STAT_NONE;
                        end
                     end
                     REQ_DROP: begin
                        // only an unread record leaves a gap in the ranks
                        if (fnd) begin
                           valid_in[hix] = 1'b0;
                           count_in      = CNT_W'(count_ff - 1'b1);
                           go_update     = !hit_read_in;
                        end else begin
                           status_in = STAT_NONE;
                        end
                     end
                     default: begin
                     end
                  endcase
                  if (go_update) begin
                     issue_in = 1'b1;
                     idx_in   = '0;
                     if (op_ff == REQ_PUSH) begin
                        valid_in[free_idx_in] = 1'b1;
                        count_in              = CNT_W'(count_ff + 1'b1);
                     end
                  end
               end
            end
         end
         S_UPDATE: begin
            if (dvld_ff) begin
               case (op_ff)
                  REQ_PUSH: begin
                     if (didx_ff == free_idx_ff) begin
                        // new record, unread and newest
                        wr_en                        = 1'b1;
                        wr_data[KEY_W-1:0]           = key_ff;
                        wr_data[FLG_LO +: FLAG_W]    = flags_ff;
                        wr_data[READ_BIT]            = 1'b0;
                        wr_data[RANK_LO +: RANK_W]   = '0;
                     end else if (ent_v && !ent_rd) begin
                        wr_en                        = 1'b1;
                        wr_data[RANK_LO +: RANK_W]   = RANK_W'(ent_rank + 1'b1);
                     end
                  end
                  REQ_NEXT: begin
                     if (didx_ff == hit_idx_ff) begin
                        wr_en             = 1'b1;
                        wr_data[READ_BIT] = 1'b1;
                     end else if (ent_v && !ent_rd && (ent_rank > hit_rank_ff)) begin
                        wr_en                      = 1'b1;
                        wr_data[RANK_LO +: RANK_W] = RANK_W'(ent_rank - 1'b1);
                     end
                  end
                  REQ_DROP: begin
                     // close the gap left by the dropped unread record
                     if (ent_v && !ent_rd && (ent_rank > hit_rank_ff)) begin
                        wr_en                      = 1'b1;
                        wr_data[RANK_LO +: RANK_W] = RANK_W'(ent_rank - 1'b1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // response register, held until the transaction is taken
   always_comb begin
      logic ret_v;

      ret_v        = (op_ff == REQ_NEXT) && found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in                = 1'b1;
         rsp_user_in                 = status_ff;
         rsp_data_in                 = '0;
         rsp_data_in[0]              = ret_v;
         rsp_data_in[1 +: KEY_W]     = ret_v ? ret_key_ff : '0;
         rsp_data_in[KEY_W + 1 + FLAG_FLUSH]   = ret_v && ret_flags_ff[FLAG_FLUSH];
         rsp_data_in[KEY_W + 1 + FLAG_UNICAST] = ret_v && ret_flags_ff[FLAG_UNICAST];
         rsp_data_in[KEY_W + 1 + FLAG_AUX]     = ret_v && ret_flags_ff[FLAG_AUX];
         rsp_data_in[KEY_W + 1 + FLAG_W]       = (count_ff == '0);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         dvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         dvld_ff      <= dvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      flags_ff      <= flags_in;
      idx_ff        <= idx_in;
      didx_ff       <= didx_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_read_ff   <= hit_read_in;
      hit_rank_ff   <= hit_rank_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      ret_key_ff    <= ret_key_in;
      ret_flags_ff  <= ret_flags_in;
      status_ff     <= status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

endmodule

`default_nettype wire

// ===== dv/dedup_pending_record_table_tb.sv =====
// self-checking testbench of the deduplicating pending record table
`default_nettype none

module dedup_pending_record_table_tb;
   import dprt_pkg::*;

   localparam int DEPTH      = 16;
   localparam int KEY_W      = 32;
   localparam int REQ_DATA_W = ((KEY_W + FLAG_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((KEY_W + FLAG_W + 2 + 7) / 8) * 8;
   localparam int KEY_POOL_N = 24;

   // one response as the table should give it
   typedef struct packed {
      status_type         status;
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [FLAG_W-1:0]  flags;
      logic               empty;
   } table_response_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = REQ_PUSH;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   // shadow copy of the record table
   logic              slot_used [DEPTH];
   logic [KEY_W-1:0]  slot_key  [DEPTH];
   logic [FLAG_W-1:0] slot_flags[DEPTH];
   logic              slot_read [DEPTH];
   int unsigned       slot_age  [DEPTH];

   table_response_type predicted_responses[$];
   logic [KEY_W-1:0]  key_pool[KEY_POOL_N];
   int                error_count = 0;
   bit                idling_on = 1'b1;
   int                ready_hold = 0;

   dedup_pending_record_table #(
      .DEPTH(DEPTH),
      .KEY_W(KEY_W)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #1 clock = ~clock;

   // unread records older than the one leaving the unread set move up one place
   function automatic void close_age_gap(input int unsigned gone_age);
      for (int i = 0; i < DEPTH; i++) begin
         if (slot_used[i] && !slot_read[i] && slot_age[i] > gone_age) begin
            slot_age[i]--;
         end
      end
   endfunction

   // apply one request to the shadow table and work out its response
   function automatic table_response_type predict_response(input req_kind_type kind,
                                                          input logic [KEY_W-1:0] key,
                                                          input logic [FLAG_W-1:0] flags);
      table_response_type rsp;
      int hit;
      int slot;
      rsp = '0;
      rsp.status = STAT_DONE;
      hit = -1;
      slot = -1;
      for (int i = 0; i < DEPTH; i++) begin
         if (hit < 0 && slot_used[i] && slot_key[i] == key) begin
            hit = i;
         end
      end
      case (kind)
         REQ_PUSH: begin
            // a held key wins over a full table
            if (hit >= 0) begin
               rsp.status = STAT_DUP;
            end else begin
               for (int i = DEPTH - 1; i >= 0; i--) begin
                  if (!slot_used[i]) begin
                     slot = i;
                  end
               end
               if (slot < 0) begin
                  rsp.status = STAT_FULL;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (slot_used[i] && !slot_read[i]) begin
                        slot_age[i]++;
                     end
                  end
                  slot_used[slot]  = 1'b1;
                  slot_key[slot]   = key;
                  slot_flags[slot] = flags;
                  slot_read[slot]  = 1'b0;
                  slot_age[slot]   = 0;
               end
            end
         end
         REQ_NEXT: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (slot_used[i] && !slot_read[i] &&
                   (slot < 0 || slot_age[i] < slot_age[slot])) begin
                  slot = i;
               end
            end
            if (slot < 0) begin
               rsp.status = STAT_NONE;
            end else begin
               rsp.valid = 1'b1;
               rsp.key   = slot_key[slot];
               rsp.flags = slot_flags[slot];
               slot_read[slot] = 1'b1;
               close_age_gap(slot_age[slot]);
            end
         end
         REQ_DROP: begin
            if (hit < 0) begin
               rsp.status = STAT_NONE;
            end else begin
               slot_used[hit] = 1'b0;
               if (!slot_read[hit]) begin
                  close_age_gap(slot_age[hit]);
               end
            end
         end
         default: begin
            for (int i = 0; i < DEPTH; i++) begin
               slot_used[i] = 1'b0;
            end
         end
      endcase
      rsp.empty = 1'b1;
      for (int i = 0; i < DEPTH; i++) begin
         if (slot_used[i]) begin
            rsp.empty = 1'b0;
         end
      end
      return rsp;
   endfunction

   // hand one request to the table, with an occasional idle burst in front
   task automatic send_request(input req_kind_type kind, input logic [KEY_W-1:0] key,
                               input logic [FLAG_W-1:0] flags);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({flags, key});
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      predicted_responses.push_back(predict_response(kind, key, flags));
   endtask

   task automatic report_mismatch(input string field, input logic [KEY_W-1:0] exp_val,
                                  input logic [KEY_W-1:0] act_val);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
      error_count++;
   endtask

   // response side stalls in random bursts while idling is on
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         ready_hold <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      table_response_type exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_responses.size() == 0) begin
            $display("%0t: response with none expected, actual tuser %0h tdata %0h",
                     $time, rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            exp_rsp = predicted_responses.pop_front();
            if (rsp_tuser != exp_rsp.status)
               report_mismatch("status", exp_rsp.status, rsp_tuser);
            if (rsp_tdata[0] != exp_rsp.valid)
               report_mismatch("out_valid", exp_rsp.valid, rsp_tdata[0]);
            if (rsp_tdata[KEY_W:1] != exp_rsp.key)
               report_mismatch("out_key", exp_rsp.key, rsp_tdata[KEY_W:1]);
            if (rsp_tdata[KEY_W+1+FLAG_FLUSH] != exp_rsp.flags[FLAG_FLUSH])
               report_mismatch("out_flush_cache", exp_rsp.flags[FLAG_FLUSH],
                               rsp_tdata[KEY_W+1+FLAG_FLUSH]);
            if (rsp_tdata[KEY_W+1+FLAG_UNICAST] != exp_rsp.flags[FLAG_UNICAST])
               report_mismatch("out_unicast", exp_rsp.flags[FLAG_UNICAST],
                               rsp_tdata[KEY_W+1+FLAG_UNICAST]);
            if (rsp_tdata[KEY_W+1+FLAG_AUX] != exp_rsp.flags[FLAG_AUX])
               report_mismatch("out_auxiliary", exp_rsp.flags[FLAG_AUX],
                               rsp_tdata[KEY_W+1+FLAG_AUX]);
            if (rsp_tdata[KEY_W+1+FLAG_W] != exp_rsp.empty)
               report_mismatch("is_empty", exp_rsp.empty, rsp_tdata[KEY_W+1+FLAG_W]);
         end
      end
   end

   // lookups on an empty table, extreme keys, duplicates of unread and read records
   task automatic test_basic_requests();
      send_request(REQ_NEXT, 32'h1234_5678, 3'b111);
      send_request(REQ_DROP, 32'h0000_0000, 3'b000);
      send_request(REQ_PUSH, 32'h0000_0000, 3'b000);
      send_request(REQ_PUSH, 32'hFFFF_FFFF, 3'b111);
      send_request(REQ_PUSH, 32'h0000_0000, 3'b110);
      send_request(REQ_NEXT, 32'hFFFF_FFFF, 3'b000);
      send_request(REQ_PUSH, 32'hFFFF_FFFF, 3'b010);
      send_request(REQ_NEXT, 32'h0000_0000, 3'b101);
      send_request(REQ_NEXT, 32'h0000_0000, 3'b000);
      send_request(REQ_DROP, 32'h0000_0000, 3'b000);
   endtask

   // fill the table, refuse a new key and a duplicate, reuse the lowest free slot, flush
   task automatic test_full_table();
      for (int i = 1; i < DEPTH; i++) begin
         send_request(REQ_PUSH, 32'hA5A5_0000 + i, FLAG_W'($urandom_range(0, 7)));
      end
      send_request(REQ_PUSH, 32'h5A5A_5A5A, 3'b001);
      send_request(REQ_PUSH, 32'hFFFF_FFFF, 3'b100);
      send_request(REQ_DROP, 32'hA5A5_0007, 3'b000);
      send_request(REQ_NEXT, 32'h0000_0000, 3'b000);
      send_request(REQ_PUSH, 32'h5A5A_5A5A, 3'b011);
      send_request(REQ_NEXT, 32'h0000_0000, 3'b000);
      send_request(REQ_FLUSH, 32'hDEAD_BEEF, 3'b111);
      send_request(REQ_FLUSH, 32'h0000_0000, 3'b000);
   endtask

   // mostly keys from a small pool so that duplicates, drops and a full table recur
   task automatic test_random_traffic(input int count);
      req_kind_type kind;
      logic [KEY_W-1:0] key;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)      kind = REQ_PUSH;
         else if (pick < 70) kind = REQ_NEXT;
         else if (pick < 97) kind = REQ_DROP;
         else                kind = REQ_FLUSH;
         if ($urandom_range(0, 4) == 0) key = $urandom;
         else                           key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
         send_request(kind, key, FLAG_W'($urandom_range(0, 7)));
      end
   endtask

   // last stretch with both sides always ready
   task automatic test_quiet_tail(input int count);
      idling_on = 1'b0;
      test_random_traffic(count);
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_used[i] = 1'b0;
      end
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL_N; i++) begin
         key_pool[i] = $urandom;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_requests();
      test_full_table();
      test_random_traffic(1120);
      test_quiet_tail(150);

      // let the table drain, then a little longer than one request takes
      req_tvalid <= 1'b0;
      while (predicted_responses.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
